// File: rtl/thermocouple_poly_eval_unit_assert.svh
// assertion macros for the thermocouple polynomial evaluator
// used by thermocouple_poly_eval_unit.sv, the rtl file that carries assertions; no other dependencies
`ifndef THERMOCOUPLE_POLY_EVAL_UNIT_ASSERT_SVH
`define THERMOCOUPLE_POLY_EVAL_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// condition must hold at every clock edge out of reset
`define TPE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define TPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPE_ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define TPE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: rtl/tpe_pkg.sv
// shared constants, coefficient table and shift table for the polynomial evaluator
// no dependencies
`default_nettype none

package tpe_pkg;

    localparam int NUM_COEF   = 14;
    localparam int MAX_TERMS  = 16;
    localparam int TERM_LIMIT = (NUM_COEF < MAX_TERMS) ? NUM_COEF : MAX_TERMS;

    localparam int TEMP_W  = 16;
    localparam int VOLT_W  = 24;
    localparam int TC_W    = 4;
    localparam int ACC_W   = 48;
    localparam int HALF_W  = ACC_W / 2;
    localparam int MUL_A_W = HALF_W + 1;
    localparam int MUL_P_W = MUL_A_W + TEMP_W;
    localparam int LO_W    = MUL_P_W + 1;
    localparam int WIDE_W  = 64;
    localparam int SHIFT_W = 5;

    localparam logic [TC_W-1:0] TERM_MAX = TC_W'(TERM_LIMIT);

    localparam logic signed [TEMP_W-1:0] T_LOW  = -16'sd17280;
    localparam logic signed [TEMP_W-1:0] T_HIGH = 16'sd0;

    localparam logic signed [ACC_W-1:0] V_LOW  = -48'sd6500000;
    localparam logic signed [ACC_W-1:0] V_HIGH = 48'sd0;

    localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;

    typedef logic signed [ACC_W-1:0]   acc_t;
    typedef logic signed [TEMP_W-1:0]  temp_t;
    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_P_W-1:0] mul_p_t;

    // scaled coefficient of term idx
    function automatic acc_t tpe_coef(input logic [TC_W-1:0] idx);
        acc_t c;
        case (idx)
            4'd1:    c = 48'sd7689405557;
            4'd2:    c = 48'sd1523739544;
            4'd3:    c = -48'sd6699981365;
            4'd4:    c = -48'sd56735153691;
            4'd5:    c = -48'sd334688288627;
            4'd6:    c = -48'sd1343356159611;
            4'd7:    c = -48'sd3795456528340;
            4'd8:    c = -48'sd7590743560238;
            4'd9:    c = -48'sd21267179971862;
            4'd10:   c = -48'sd20320508885769;
            4'd11:   c = -48'sd25146143796342;
            4'd12:   c = -48'sd36234007942305;
            4'd13:   c = -48'sd46068173877170;
            default: c = 48'sd0;
        endcase
        return c;
    endfunction

    // scale step between horner level idx and level idx-1
    function automatic logic [SHIFT_W-1:0] tpe_shift(input logic [TC_W-1:0] idx);
        logic [SHIFT_W-1:0] s;
        case (idx)
            4'd1:    s = 5'd23;
            4'd9:    s = 5'd15;
            4'd11:   s = 5'd15;
            4'd12:   s = 5'd16;
            4'd13:   s = 5'd17;
            default: s = 5'd14;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tpe_mult.sv
// shared signed multiplier with registered product, 25 x 16 bits
// depends on tpe_pkg
`default_nettype none

module tpe_mult (
    input  wire logic            clk,
    input  wire tpe_pkg::mul_a_t a,
    input  wire tpe_pkg::temp_t  b,
    output tpe_pkg::mul_p_t      prod
);
    import tpe_pkg::*;

    mul_p_t prod_reg;
    mul_p_t prod_next;

    // one partial product per cycle, product registered in the cycle after
    always_comb
    begin
        prod_next = MUL_P_W'(a) * MUL_P_W'(b);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// File: rtl/thermocouple_poly_eval_unit.sv
// Type E thermocouple polynomial evaluation: stream in temperature, stream out EMF in nV.
// The polynomial is evaluated with Horner's rule on one shared 25 x 16 bit
// multiplier (tpe_mult). Each Horner step runs in order: low half of the
// accumulator times the sample, high half times the sample, recombine with
// rounding and scale shift, then add the next coefficient with 48-bit
// saturation. With n terms in use the sequencer starts at coefficient n-1, does one
// Horner step per lower coefficient, then loads the result into the output register;
// s_tready is low from the input transfer until the sequencer is back in idle, so a
// new sample is taken only after the last one has left the sequencer. The output
// register holds a finished result until it is taken, so the next sample may be
// transferred meanwhile; a result that finds the output register still full waits in
// the sequencer with s_tready low. term_count is written through cfg_we / cfg_wdata,
// by the user only while the block is idle; the block itself does not enforce this.
// Values above 14 use 14 terms and zero gives a result of 0. Samples are clamped to
// [-270 C, 0 C] first and the result is saturated to [-6500000, 0] nV.
// depends on tpe_pkg, tpe_mult and thermocouple_poly_eval_unit_assert.svh
`default_nettype none

`include "thermocouple_poly_eval_unit_assert.svh"

module thermocouple_poly_eval_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [tpe_pkg::TC_W-1:0]      cfg_wdata,    // term_count
    // sample input
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [tpe_pkg::TEMP_W-1:0]    s_tdata,      // [15:0] temperature
    // result output
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [tpe_pkg::VOLT_W-1:0]         m_tdata       // [23:0] voltage
);
    import tpe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SHIFT,
        ST_ACC,
        ST_OUT
    } state_t;

    state_t                state_reg,  state_next;
    logic [TC_W-1:0]       tc_reg,     tc_next;
    logic [TC_W-1:0]       lvl_reg,    lvl_next;
    temp_t                 temp_reg,   temp_next;
    acc_t                  acc_reg,    acc_next;
    logic signed [LO_W-1:0]   lo_reg,  lo_next;
    logic signed [WIDE_W-1:0] rs_reg,  rs_next;
    logic                  mvalid_reg, mvalid_next;
    logic [VOLT_W-1:0]     mdata_reg,  mdata_next;

    mul_a_t                mul_a;
    mul_p_t                mul_p;
    temp_t                 temp_in;
    temp_t                 temp_clamped;
    logic [TC_W-1:0]       terms;
    logic [SHIFT_W-1:0]    shift_amt;
    logic [LO_W-1:0]       round_bit;
    logic signed [WIDE_W-1:0] hi_ext;
    logic signed [WIDE_W-1:0] wide_sum;
    logic signed [WIDE_W-1:0] acc_sum;
    acc_t                  acc_sat;
    acc_t                  volt_sat;
    logic                  out_free;

    // shared multiplier
    tpe_mult u_mult (
        .clk  (clk),
        .a    (mul_a),
        .b    (temp_reg),
        .prod (mul_p)
    );

    // operand select: low half unsigned, high half signed
    always_comb
    begin
        if (state_reg == ST_MUL_LO)
        begin
            mul_a = {1'b0, acc_reg[HALF_W-1:0]};
        end
        else
        begin
            mul_a = {acc_reg[ACC_W-1], acc_reg[ACC_W-1:HALF_W]};
        end
    end

    // sample clamp and term limit
    always_comb
    begin
        temp_in = $signed(s_tdata);
        if (temp_in < T_LOW)
        begin
            temp_clamped = T_LOW;
        end
        else if (temp_in > T_HIGH)
        begin
            temp_clamped = T_HIGH;
        end
        else
        begin
            temp_clamped = temp_in;
        end
        terms = (tc_reg > TERM_MAX) ? TERM_MAX : tc_reg;
    end

    // recombine halves, round, scale and accumulate
    always_comb
    begin
        shift_amt = tpe_shift(lvl_reg);
        round_bit = LO_W'(1) << (shift_amt - SHIFT_W'(1));
        hi_ext    = WIDE_W'(mul_p);
        wide_sum  = (hi_ext <<< HALF_W) + WIDE_W'(lo_reg);
        acc_sum   = WIDE_W'(tpe_coef(lvl_reg - TC_W'(1))) + rs_reg;
        if (acc_sum > WIDE_W'(ACC_MAX))
        begin
            acc_sat = ACC_MAX;
        end
        else if (acc_sum < WIDE_W'(ACC_MIN))
        begin
            acc_sat = ACC_MIN;
        end
        else
        begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
        if (acc_reg < V_LOW)
        begin
            volt_sat = V_LOW;
        end
        else if (acc_reg > V_HIGH)
        begin
            volt_sat = V_HIGH;
        end
        else
        begin
            volt_sat = acc_reg;
        end
        out_free = !mvalid_reg || m_tready;
    end

    // sequencer next state
    always_comb
    begin
        state_next  = state_reg;
        tc_next     = tc_reg;
        lvl_next    = lvl_reg;
        temp_next   = temp_reg;
        acc_next    = acc_reg;
        lo_next     = lo_reg;
        rs_next     = rs_reg;
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;

        if (cfg_we)
        begin
            tc_next = cfg_wdata;
        end
        if (mvalid_reg && m_tready)
        begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    temp_next = temp_clamped;
                    if (terms == '0)
                    begin
                        acc_next   = '0;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        acc_next   = tpe_coef(terms - TC_W'(1));
                        lvl_next   = terms - TC_W'(1);
                        state_next = (terms == TC_W'(1)) ? ST_OUT : ST_MUL_LO;
                    end
                end
            end
            ST_MUL_LO:
            begin
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                lo_next    = LO_W'(mul_p) + $signed(round_bit);
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                rs_next    = wide_sum >>> shift_amt;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_next   = acc_sat;
                lvl_next   = lvl_reg - TC_W'(1);
                state_next = (lvl_reg == TC_W'(1)) ? ST_OUT : ST_MUL_LO;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    mvalid_next = 1'b1;
                    mdata_next  = volt_sat[VOLT_W-1:0];
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            tc_reg     <= TC_W'(NUM_COEF);
            lvl_reg    <= '0;
            temp_reg   <= '0;
            acc_reg    <= '0;
            lo_reg     <= '0;
            rs_reg     <= '0;
            mvalid_reg <= 1'b0;
            mdata_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            tc_reg     <= tc_next;
            lvl_reg    <= lvl_next;
            temp_reg   <= temp_next;
            acc_reg    <= acc_next;
            lo_reg     <= lo_next;
            rs_reg     <= rs_next;
            mvalid_reg <= mvalid_next;
            mdata_reg  <= mdata_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

    // horner level stays inside the coefficient table
    `TPE_ASSERT_ALWAYS(a_lvl_range, clk, rst_n, lvl_reg < TC_W'(NUM_COEF), "horner level out of range")
    // a held result is always a saturated voltage
    `TPE_ASSERT_ALWAYS(a_volt_range, clk, rst_n, !mvalid_reg || (($signed(mdata_reg) <= 24'sd0) && ($signed(mdata_reg) >= -24'sd6500000)), "result outside voltage range")
    // an input transfer starts a busy period
    `TPE_ASSERT_NEXT(a_busy_after_in, clk, rst_n, s_tvalid && s_tready, !s_tready, "ready after input transfer")
    // every accumulate step either loops back or finishes
    `TPE_ASSERT_NEXT(a_acc_next, clk, rst_n, state_reg == ST_ACC, (state_reg == ST_MUL_LO) || (state_reg == ST_OUT), "bad step after accumulate")

endmodule

`default_nettype wire
